/* hdl/nrgfr_pkg.sv */
// ----------------------------------------------------------------------------
// NMEA RMC/GGA field router package
// Field widths, character codes and field codes shared by the router and its
// channel interfaces.
// ----------------------------------------------------------------------------
package nrgfr_pkg;

   localparam int BYTE_W       = 8;
   localparam int FIELD_CODE_W = 5;
   localparam int CHAR_INDEX_W = 3;
   localparam int LENGTH_W     = 7;
   localparam int COUNT_W      = 4;

   // sentence length limit, counting the leading '$'
   localparam logic [LENGTH_W-1:0] MAX_SENTENCE = LENGTH_W'(82);
   localparam logic [COUNT_W-1:0]  LAST_COMMA   = COUNT_W'(10);

   localparam logic [BYTE_W-1:0] ASCII_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] ASCII_COMMA  = 8'h2C;

   typedef enum logic [FIELD_CODE_W-1:0] {
      F_HOUR     = 5'd0,
      F_MINUTE   = 5'd1,
      F_SECOND   = 5'd2,
      F_VALID    = 5'd3,
      F_LATDEG   = 5'd4,
      F_LATMIN   = 5'd5,
      F_LATHEM   = 5'd6,
      F_LONDEG   = 5'd7,
      F_LONMIN   = 5'd8,
      F_LONHEM   = 5'd9,
      F_SPEED    = 5'd10,
      F_DAY      = 5'd11,
      F_MONTH    = 5'd12,
      F_YEAR     = 5'd13,
      F_SATS     = 5'd14,
      F_ACCURACY = 5'd15,
      F_ALTITUDE = 5'd16,
      F_ALTUNIT  = 5'd17,
      F_NONE     = 5'd31
   } field_code_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'b001,
      MODE_HEADER = 3'b010,
      MODE_BODY   = 3'b100
   } mode_type;

   typedef struct packed {
      field_code_type             code;
      logic [CHAR_INDEX_W-1:0]    sub;
   } route_type;

endpackage

/* hdl/nrgfr_if.sv */
// ----------------------------------------------------------------------------
// NMEA router channel interfaces
// Valid/ready channels for the byte input and the routed character output.
// ----------------------------------------------------------------------------
interface nrgfr_req_if;
   import nrgfr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface nrgfr_rsp_if;
   import nrgfr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    sentence_kind;
   logic [FIELD_CODE_W-1:0] field_code;
   logic [CHAR_INDEX_W-1:0] char_index;
   logic [BYTE_W-1:0]       char_value;

   modport source (output valid, output sentence_kind, output field_code,
                   output char_index, output char_value, input ready);
   modport sink   (input valid, input sentence_kind, input field_code,
                   input char_index, input char_value, output ready);
endinterface

/* hdl/nmea_rmc_gga_field_router.sv */
// ----------------------------------------------------------------------------
// NMEA RMC/GGA field router
// Parses $GPRMC and $GPGGA sentences and emits each captured character with
// its field code and index within the field.
// ----------------------------------------------------------------------------
// One byte is taken per cycle and its routed character, if any, appears in the
// output register on the next cycle. The decode of a byte is a single pass
// through the header/comma state and a small routing table, so the input keeps
// taking a byte every cycle as long as the output register is empty or being
// drained in the same cycle. A '$' restarts parsing at any time; a header not
// starting GPRMC/GPGGA is dropped until the next '$'. Sentences are cut off after
// MAX_LENGTH bytes (82 by default) or after the first character of field ten.
module nmea_rmc_gga_field_router #(
   parameter logic [nrgfr_pkg::LENGTH_W-1:0] MAX_LENGTH = nrgfr_pkg::MAX_SENTENCE
) (
   input logic          clock,
   input logic          reset,
   nrgfr_req_if.sink    req,
   nrgfr_rsp_if.source  rsp
);
   import nrgfr_pkg::*;

   mode_type                mode_ff, mode_in;
   logic                    rmc_match_ff, rmc_match_in;
   logic                    gga_match_ff, gga_match_in;
   logic                    kind_gga_ff, kind_gga_in;
   logic [COUNT_W-1:0]      comma_ff, comma_in;
   logic [COUNT_W-1:0]      cif_ff, cif_in;
   logic [LENGTH_W-1:0]     length_ff, length_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff;
   field_code_type          rsp_code_ff;
   logic [CHAR_INDEX_W-1:0] rsp_index_ff;
   logic [BYTE_W-1:0]       rsp_char_ff;

   logic                    accept;
   logic                    emit;
   route_type               route_sel;
   logic [BYTE_W-1:0]       b;

   // two/two/two split used by time and date
   function automatic route_type split_triple(input logic [COUNT_W-1:0] idx,
                                              input field_code_type base);
      route_type r;
      r.code = F_NONE;
      r.sub  = '0;
      if (idx < 4'd2) begin
         r.code = base;
         r.sub  = idx[CHAR_INDEX_W-1:0];
      end else if (idx < 4'd4) begin
         r.code = field_code_type'(base + 5'd1);
         r.sub  = CHAR_INDEX_W'(idx - 4'd2);
      end else if (idx < 4'd6) begin
         r.code = field_code_type'(base + 5'd2);
         r.sub  = CHAR_INDEX_W'(idx - 4'd4);
      end
      return r;
   endfunction

   function automatic route_type route(input logic gga,
                                       input logic [COUNT_W-1:0] fld,
                                       input logic [COUNT_W-1:0] idx);
      route_type           r;
      logic [COUNT_W-1:0]  pos_fld;
      r.code  = F_NONE;
      r.sub   = '0;
      pos_fld = '0;
      if (fld == 4'd1) begin
         r = split_triple(idx, F_HOUR);
      end else if (!gga && fld == 4'd2) begin
         if (idx == 4'd0) r.code = F_VALID;
      end else if (!gga && fld == 4'd7) begin
         r.sub = idx[CHAR_INDEX_W-1:0];
         if (idx < 4'd5) r.code = F_SPEED;
      end else if (!gga && fld == 4'd9) begin
         r = split_triple(idx, F_DAY);
      end else if (gga && fld == 4'd7) begin
         r.sub = idx[CHAR_INDEX_W-1:0];
         if (idx < 4'd2) r.code = F_SATS;
      end else if (gga && fld == 4'd8) begin
         r.sub = idx[CHAR_INDEX_W-1:0];
         if (idx < 4'd3) r.code = F_ACCURACY;
      end else if (gga && fld == 4'd9) begin
         r.sub = idx[CHAR_INDEX_W-1:0];
         if (idx < 4'd5) r.code = F_ALTITUDE;
      end else if (gga && fld == 4'd10) begin
         if (idx == 4'd0) r.code = F_ALTUNIT;
      end else begin
         // RMC carries latitude/longitude one field later than GGA
         pos_fld = gga ? fld : fld - 4'd1;
         if (!gga && (fld < 4'd3 || fld > 4'd6)) pos_fld = '0;
         unique case (pos_fld)
            4'd2: begin
               if (idx < 4'd2) begin
                  r.code = F_LATDEG;
                  r.sub  = idx[CHAR_INDEX_W-1:0];
               end else if (idx < 4'd9) begin
                  r.code = F_LATMIN;
                  r.sub  = CHAR_INDEX_W'(idx - 4'd2);
               end
            end
            4'd3: if (idx == 4'd0) r.code = F_LATHEM;
            4'd4: begin
               if (idx < 4'd3) begin
                  r.code = F_LONDEG;
                  r.sub  = idx[CHAR_INDEX_W-1:0];
               end else if (idx < 4'd10) begin
                  r.code = F_LONMIN;
                  r.sub  = CHAR_INDEX_W'(idx - 4'd3);
               end
            end
            4'd5: if (idx == 4'd0) r.code = F_LONHEM;
            default: r.code = F_NONE;
         endcase
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] tag_char(input logic gga,
                                                  input logic [2:0] pos);
      logic [BYTE_W-1:0] c;
      unique case (pos)
         3'd1:    c = "G";
         3'd2:    c = "P";
         3'd3:    c = gga ? "G" : "R";
         3'd4:    c = gga ? "G" : "M";
         3'd5:    c = gga ? "A" : "C";
         default: c = '0;
      endcase
      return c;
   endfunction

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign b         = req.byte_in;

   always_comb begin
      mode_in      = mode_ff;
      rmc_match_in = rmc_match_ff;
      gga_match_in = gga_match_ff;
      kind_gga_in  = kind_gga_ff;
      comma_in     = comma_ff;
      cif_in       = cif_ff;
      length_in    = length_ff;
      emit         = 1'b0;
      route_sel    = route(kind_gga_ff, comma_ff, cif_ff);

      if (b == ASCII_DOLLAR) begin
         mode_in      = MODE_HEADER;
         rmc_match_in = 1'b1;
         gga_match_in = 1'b1;
         comma_in     = '0;
         cif_in       = '0;
         length_in    = LENGTH_W'(1);
      end else if (mode_ff == MODE_HEADER || mode_ff == MODE_BODY) begin
         if (length_ff >= MAX_LENGTH) begin
            mode_in = MODE_IDLE;
         end else begin
            if (length_ff != '1) length_in = length_ff + LENGTH_W'(1);
            if (mode_ff == MODE_HEADER) begin
               if (b == ASCII_COMMA) begin
                  if (length_ff >= LENGTH_W'(6) && (rmc_match_ff || gga_match_ff)) begin
                     kind_gga_in = gga_match_ff;
                     mode_in     = MODE_BODY;
                     comma_in    = COUNT_W'(1);
                     cif_in      = '0;
                  end else begin
                     mode_in = MODE_IDLE;
                  end
               end else if (length_ff >= LENGTH_W'(1) && length_ff <= LENGTH_W'(5)) begin
                  if (b != tag_char(1'b0, length_ff[2:0])) rmc_match_in = 1'b0;
                  if (b != tag_char(1'b1, length_ff[2:0])) gga_match_in = 1'b0;
               end
            end else if (comma_ff >= LAST_COMMA) begin
               // first byte of field ten closes the sentence
               mode_in        = MODE_IDLE;
               emit           = (b != ASCII_COMMA) && kind_gga_ff;
               route_sel.code = F_ALTUNIT;
               route_sel.sub  = '0;
            end else if (b == ASCII_COMMA) begin
               comma_in = comma_ff + COUNT_W'(1);
               cif_in   = '0;
            end else begin
               if (cif_ff != '1) cif_in = cif_ff + COUNT_W'(1);
               emit = (route_sel.code != F_NONE);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         rmc_match_ff <= 1'b0;
         gga_match_ff <= 1'b0;
         kind_gga_ff  <= 1'b0;
         comma_ff     <= '0;
         cif_ff       <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff      <= mode_in;
            rmc_match_ff <= rmc_match_in;
            gga_match_ff <= gga_match_in;
            kind_gga_ff  <= kind_gga_in;
            comma_ff     <= comma_in;
            cif_ff       <= cif_in;
            length_ff    <= length_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_kind_ff  <= kind_gga_ff;
         rsp_code_ff  <= route_sel.code;
         rsp_index_ff <= route_sel.sub;
         rsp_char_ff  <= b;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.sentence_kind = rsp_kind_ff;
   assign rsp.field_code    = rsp_code_ff;
   assign rsp.char_index    = rsp_index_ff;
   assign rsp.char_value    = rsp_char_ff;

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_code_ff <= F_ALTUNIT)
      else $error("routed word carries an unused field code");

   a_gga_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_code_ff == F_ALTUNIT || rsp_code_ff == F_SATS ||
                       rsp_code_ff == F_ACCURACY || rsp_code_ff == F_ALTITUDE)
      |-> rsp_kind_ff)
      else $error("GGA-only field routed from an RMC sentence");

   a_dollar_restart: assert property (@(posedge clock) disable iff (reset)
      accept && b == ASCII_DOLLAR |=> mode_ff == MODE_HEADER &&
                                      length_ff == LENGTH_W'(1) && comma_ff == '0)
      else $error("dollar did not restart the sentence");

   a_comma_bound: assert property (@(posedge clock) disable iff (reset)
      comma_ff <= LAST_COMMA)
      else $error("comma count ran past field ten");

   a_header_no_word: assert property (@(posedge clock) disable iff (reset)
      accept && mode_ff != MODE_BODY |=> !rsp_valid_ff)
      else $error("word emitted outside the sentence body");

endmodule

/* dv/tb_nmea_rmc_gga_field_router.sv */
// ----------------------------------------------------------------------------
// NMEA RMC/GGA field router testbench
// Sends a short table of directed bytes and then random RMC/GGA sentences,
// noise and broken headers to the router. A local model of the parser
// predicts each routed character, and every output word is checked against
// it in order. Both channels throttle at random, and the output is held off
// once for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb_nmea_rmc_gga_field_router;
   import nrgfr_pkg::*;

   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 8;
   localparam int DIR_ROWS     = 24;
   localparam int SAT_LENGTH   = 127;

   typedef struct packed {
      logic                    kind;
      field_code_type          code;
      logic [CHAR_INDEX_W-1:0] idx;
      logic [BYTE_W-1:0]       ch;
   } routed_char_type;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_RESULT
   } check_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] b;
      check_kind_type    chk;
      routed_char_type   want;
   } dir_row_type;

   localparam routed_char_type NO_CHAR = '0;
   localparam logic [BYTE_W-1:0] RMC_TAG [5] = '{"G", "P", "R", "M", "C"};
   localparam logic [BYTE_W-1:0] GGA_TAG [5] = '{"G", "P", "G", "G", "A"};
   localparam string CHAR_POOL = "0123456789.NSEWAVM-";

   // GGA sentence cut short after field ten, then a header that is too short
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      '{8'h00,        CHK_NONE,   NO_CHAR},
      '{8'hFF,        CHK_NONE,   NO_CHAR},
      '{ASCII_DOLLAR, CHK_MODEL,  NO_CHAR},
      '{"G",          CHK_MODEL,  NO_CHAR},
      '{"P",          CHK_MODEL,  NO_CHAR},
      '{"G",          CHK_MODEL,  NO_CHAR},
      '{"G",          CHK_MODEL,  NO_CHAR},
      '{"A",          CHK_MODEL,  NO_CHAR},
      '{ASCII_COMMA,  CHK_MODEL,  NO_CHAR},
      '{"1",          CHK_RESULT, '{1'b1, F_HOUR, 3'd0, "1"}},
      '{ASCII_COMMA,  CHK_MODEL,  NO_CHAR},
      '{ASCII_COMMA,  CHK_MODEL,  NO_CHAR},
      '{ASCII_COMMA,  CHK_MODEL,  NO_CHAR},
      '{ASCII_COMMA,  CHK_MODEL,  NO_CHAR},
      '{ASCII_COMMA,  CHK_MODEL,  NO_CHAR},
      '{ASCII_COMMA,  CHK_MODEL,  NO_CHAR},
      '{ASCII_COMMA,  CHK_MODEL,  NO_CHAR},
      '{ASCII_COMMA,  CHK_MODEL,  NO_CHAR},
      '{ASCII_COMMA,  CHK_MODEL,  NO_CHAR},
      '{"M",          CHK_RESULT, '{1'b1, F_ALTUNIT, 3'd0, "M"}},
      '{"x",          CHK_NONE,   NO_CHAR},
      '{ASCII_DOLLAR, CHK_MODEL,  NO_CHAR},
      '{ASCII_COMMA,  CHK_NONE,   NO_CHAR},
      '{"9",          CHK_NONE,   NO_CHAR}
   };

   logic clock;
   logic reset;

   nrgfr_req_if req ();
   nrgfr_rsp_if rsp ();

   nmea_rmc_gga_field_router DUT (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   // parser model state
   mode_type        nmea_mode;
   logic            rmc_ok;
   logic            gga_ok;
   int              comma_n;
   int              field_pos;
   int              sent_len;
   logic            is_gga;

   routed_char_type pending_chars [$];
   int              err_n;
   int              sent_n;
   int              send_idle_pct;
   int              recv_idle_pct;
   bit              hold_req;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // two/two/two split of time and date
   function automatic field_code_type split_pairs(input int idx, input field_code_type c0,
                                                  input field_code_type c1,
                                                  input field_code_type c2, output int sub);
      sub = idx % 2;
      if (idx < 2) return c0;
      if (idx < 4) return c1;
      if (idx < 6) return c2;
      sub = 0;
      return F_NONE;
   endfunction

   function automatic field_code_type route_char(input logic gga, input int fld, input int idx,
                                                 output int sub);
      int f;
      f   = fld;
      sub = 0;
      if (f == 1) return split_pairs(idx, F_HOUR, F_MINUTE, F_SECOND, sub);
      if (!gga) begin
         if (f == 2) return (idx < 1) ? F_VALID : F_NONE;
         if (f == 7) begin
            sub = idx;
            return (idx < 5) ? F_SPEED : F_NONE;
         end
         if (f == 9) return split_pairs(idx, F_DAY, F_MONTH, F_YEAR, sub);
         if (f < 3 || f > 6) return F_NONE;
         f = f - 1;  // RMC lat/lon sit one field later than GGA
      end else begin
         sub = idx;
         if (f == 7) return (idx < 2) ? F_SATS : F_NONE;
         if (f == 8) return (idx < 3) ? F_ACCURACY : F_NONE;
         if (f == 9) return (idx < 5) ? F_ALTITUDE : F_NONE;
         sub = 0;
         if (f == 10) return (idx < 1) ? F_ALTUNIT : F_NONE;
      end
      case (f)
         2: begin
            if (idx < 2) begin
               sub = idx;
               return F_LATDEG;
            end
            if (idx < 9) begin
               sub = idx - 2;
               return F_LATMIN;
            end
         end
         3: if (idx < 1) return F_LATHEM;
         4: begin
            if (idx < 3) begin
               sub = idx;
               return F_LONDEG;
            end
            if (idx < 10) begin
               sub = idx - 3;
               return F_LONMIN;
            end
         end
         5: if (idx < 1) return F_LONHEM;
         default: ;
      endcase
      sub = 0;
      return F_NONE;
   endfunction

   function automatic bit route_byte(input logic [BYTE_W-1:0] b, output routed_char_type r);
      int             pos;
      int             sub;
      field_code_type code;
      r = NO_CHAR;
      if (b == ASCII_DOLLAR) begin
         nmea_mode = MODE_HEADER;
         rmc_ok    = 1'b1;
         gga_ok    = 1'b1;
         comma_n   = 0;
         field_pos = 0;
         sent_len  = 1;
         return 1'b0;
      end
      if (nmea_mode != MODE_HEADER && nmea_mode != MODE_BODY) return 1'b0;
      if (sent_len >= int'(MAX_SENTENCE)) begin
         nmea_mode = MODE_IDLE;
         return 1'b0;
      end
      pos      = sent_len;
      sent_len = (pos < SAT_LENGTH) ? pos + 1 : SAT_LENGTH;

      if (nmea_mode == MODE_HEADER) begin
         if (b == ASCII_COMMA) begin
            if (pos >= 6 && (rmc_ok || gga_ok)) begin
               is_gga    = gga_ok;
               nmea_mode = MODE_BODY;
               comma_n   = 1;
               field_pos = 0;
            end else begin
               nmea_mode = MODE_IDLE;
            end
         end else if (pos >= 1 && pos <= 5) begin
            if (b != RMC_TAG[pos-1]) rmc_ok = 1'b0;
            if (b != GGA_TAG[pos-1]) gga_ok = 1'b0;
         end
         return 1'b0;
      end

      if (comma_n >= int'(LAST_COMMA)) begin
         // first byte of the last field closes the sentence
         nmea_mode = MODE_IDLE;
         if (b == ASCII_COMMA || !is_gga) return 1'b0;
         code = F_ALTUNIT;
         sub  = 0;
      end else begin
         if (b == ASCII_COMMA) begin
            comma_n   = comma_n + 1;
            field_pos = 0;
            return 1'b0;
         end
         code = route_char(is_gga, comma_n, field_pos, sub);
         if (field_pos < 15) field_pos = field_pos + 1;
         if (code == F_NONE) return 1'b0;
      end
      r.kind = is_gga;
      r.code = code;
      r.idx  = sub[CHAR_INDEX_W-1:0];
      r.ch   = b;
      return 1'b1;
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b, input check_kind_type chk,
                            input routed_char_type want);
      routed_char_type got;
      bit              hit;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.byte_in <= b;
      do @(posedge clock); while (!req.ready);
      sent_n++;
      hit = route_byte(b, got);
      if (chk == CHK_RESULT) pending_chars.push_back(want);
      else if (chk == CHK_MODEL && hit) pending_chars.push_back(got);
   endtask

   task automatic send_sentence();
      logic [BYTE_W-1:0] line [$];
      string             hdr;
      int                pick;
      int                n_fields;
      int                flen;
      pick = $urandom_range(99);
      if (pick < 8) begin
         repeat ($urandom_range(1, 6)) line.push_back(BYTE_W'($urandom_range(255)));
      end else begin
         hdr = ($urandom_range(1)) ? "GPRMC" : "GPGGA";
         if (pick < 16) begin
            hdr[$urandom_range(4)] = BYTE_W'($urandom_range(8'h41, 8'h5A));
         end else if (pick < 20) begin
            hdr = hdr.substr(0, $urandom_range(4) - 1);
         end else if (pick < 26) begin
            hdr = {hdr, "X"};
         end
         line.push_back(ASCII_DOLLAR);
         for (int i = 0; i < hdr.len(); i++) line.push_back(hdr[i]);
         n_fields = ($urandom_range(9)) ? $urandom_range(9, 12) : $urandom_range(0, 8);
         for (int f = 0; f < n_fields; f++) begin
            line.push_back(ASCII_COMMA);
            flen = ($urandom_range(19)) ? $urandom_range(0, 10) : $urandom_range(11, 20);
            repeat (flen) begin
               if ($urandom_range(15) == 0) line.push_back(BYTE_W'($urandom_range(255)));
               else line.push_back(CHAR_POOL[$urandom_range(CHAR_POOL.len() - 1)]);
            end
         end
         if ($urandom_range(1)) begin
            line.push_back("*");
            line.push_back("4");
            line.push_back("A");
            line.push_back(8'h0D);  // CR LF
            line.push_back(8'h0A);
         end
      end
      foreach (line[i]) send_byte(line[i], CHK_MODEL, NO_CHAR);
   endtask

   // result side: check each word, then pick ready for the next cycle
   initial begin
      int              hold_left;
      routed_char_type got;
      routed_char_type want;
      hold_left = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready) begin
            got.kind = rsp.sentence_kind;
            got.code = field_code_type'(rsp.field_code);
            got.idx  = rsp.char_index;
            got.ch   = rsp.char_value;
            if (pending_chars.size() == 0) begin
               if (err_n < 10)
                  $display("ERROR: unexpected word kind=%0d code=%0d idx=%0d char=%02h",
                           got.kind, got.code, got.idx, got.ch);
               err_n++;
            end else begin
               want = pending_chars.pop_front();
               if (got.kind !== want.kind || got.code !== want.code ||
                   got.idx !== want.idx || got.ch !== want.ch) begin
                  if (err_n < 10)
                     $display({"ERROR: exp kind=%0d code=%0d idx=%0d char=%02h, ",
                               "got kind=%0d code=%0d idx=%0d char=%02h"},
                              want.kind, want.code, want.idx, want.ch,
                              got.kind, got.code, got.idx, got.ch);
                  err_n++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog: cycles in which neither channel moves a word
   initial begin
      int stall_n;
      stall_n = 0;
      while (stall_n < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_n = 0;
         else stall_n++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int wait_n;
      nmea_mode     = MODE_IDLE;
      rmc_ok        = 1'b0;
      gga_ok        = 1'b0;
      comma_n       = 0;
      field_pos     = 0;
      sent_len      = 0;
      is_gga        = 1'b0;
      err_n         = 0;
      sent_n        = 0;
      hold_req      = 1'b0;
      send_idle_pct = 15;
      recv_idle_pct = 65;
      req.valid   <= 1'b0;
      req.byte_in <= '0;
      reset       <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         send_byte(DIR_TABLE[i].b, DIR_TABLE[i].chk, DIR_TABLE[i].want);

      while (sent_n < 560) send_sentence();
      send_idle_pct = 65;
      recv_idle_pct = 15;
      while (sent_n < 1100) send_sentence();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req      = 1'b1;  // long output hold-off while bytes keep coming
      while (sent_n < 1600) send_sentence();
      req.valid <= 1'b0;

      wait_n = 0;
      while (pending_chars.size() != 0 && wait_n < 2000) begin
         @(posedge clock);
         wait_n++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0) begin
         if (err_n < 10) $display("ERROR: %0d expected words never arrived", pending_chars.size());
         err_n += pending_chars.size();
      end
      if (err_n == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
